FILE: rtl/sorted_insertion_priority_queue_core_defines.svh
// Assertion macros used by the sorted insertion priority queue RTL.
// Included by the top level; depends on nothing else.
`ifndef SORTED_INSERTION_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_INSERTION_PRIORITY_QUEUE_CORE_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define SIPQ_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// The condition must hold in the cycle after the trigger.
`define SIPQ_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

FILE: rtl/sipq_pkg.sv
// Shared types and constants of the sorted insertion priority queue.
// Used by the cell, the slot finder and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sipq_pkg;

   localparam int DEPTH      = 64;
   localparam int KEY_BITS   = 16;
   localparam int TAG_BITS   = 8;
   localparam int SLOT_BITS  = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   // Configuration port geometry: one register at byte address 0.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_ORDER   = 1'b0;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [TAG_BITS-1:0]   tag_type;
   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   // Action codes of an input item.
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_POP    = 1'b1;

   // Status codes of a result item.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // What a cell loads at the next edge.
   typedef enum logic [1:0] {
      CELL_HOLD      = 2'd0,
      CELL_FROM_PREV = 2'd1,
      CELL_FROM_NEXT = 2'd2,
      CELL_LOAD      = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic        cmp_en;
      logic        ascend;
      cell_op_type op;
   } cell_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/sorted_insertion_priority_queue_core.sv
// Sequence: an accepted item is compared at accept, its slot is found, then the
// row of cells shifts and the result is registered.
// Items go one at a time: a new item is accepted only after the previous one has
// left its shift step; a stalled result holds the next item in its shift step.
// Reset (synchronous, active high) empties the queue, clears the order bit to
// descending and drops any pending result; cell contents are not cleared.
// Top level: cell row, slot finder, control and configuration. Uses sipq_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_insertion_priority_queue_core_defines.svh"

module sorted_insertion_priority_queue_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_action,
   input  sipq_pkg::key_type                    req_key,
   input  sipq_pkg::tag_type                    req_tag,
   // Result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output sipq_pkg::key_type                    rsp_out_key,
   output sipq_pkg::tag_type                    rsp_out_tag,
   output sipq_pkg::slot_type                   rsp_insert_slot,
   output sipq_pkg::count_type                  rsp_occupancy,
   // Configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [sipq_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [sipq_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [sipq_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);
   import sipq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FIND  = 3'b010,
      ST_APPLY = 3'b100
   } state_type;

   state_type     state_ff, state_in;
   count_type     count_ff, count_in;
   logic          order_ff, order_in;
   logic          action_ff;
   key_type       key_ff;
   tag_type       tag_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    status_ff, status_in;
   key_type       out_key_ff, out_key_in;
   tag_type       out_tag_ff, out_tag_in;
   slot_type      slot_out_ff, slot_out_in;
   count_type     occ_ff;

   logic          accept;
   logic          apply_go;
   logic          is_full;
   logic          is_empty;
   logic          do_ins;
   logic          do_pop;
   slot_type      slot;

   cell_ctl_type      cell_ctl [DEPTH];
   key_type           cell_key [DEPTH];
   tag_type           cell_tag [DEPTH];
   logic [DEPTH-1:0]  cell_behind;

   // Configuration register access.
   assign pready   = 1'b1;
   assign order_in = (psel && penable && pwrite && paddr[CSR_ADDR_BITS-1] == REG_ORDER)
                     ? pwdata[0] : order_ff;
   assign prdata   = (paddr[CSR_ADDR_BITS-1] == REG_ORDER)
                     ? {{(CSR_DATA_BITS-1){1'b0}}, order_ff} : '0;

   // Handshakes and the operation decision.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign apply_go  = (state_ff == ST_APPLY) && (!rsp_valid_ff || !rsp_stall);
   assign is_full   = (count_ff == COUNT_BITS'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign do_ins    = apply_go && (action_ff == ACT_INSERT) && !is_full;
   assign do_pop    = apply_go && (action_ff == ACT_POP) && !is_empty;

   // Sequencer: compare at accept, find the slot, then shift and report.
   always_comb begin
      case (state_ff)
         ST_IDLE:  state_in = accept ? ST_FIND : ST_IDLE;
         ST_FIND:  state_in = ST_APPLY;
         ST_APPLY: state_in = apply_go ? ST_IDLE : ST_APPLY;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (do_ins) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (do_pop) begin
         count_in = count_ff - COUNT_BITS'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // Per-cell control: shift back behind the slot, load at it, or shift forward.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_ctl[i].cmp_en = accept;
         cell_ctl[i].ascend = order_ff;
         if (do_ins && SLOT_BITS'(i) > slot) begin
            cell_ctl[i].op = CELL_FROM_PREV;
         end else if (do_ins && SLOT_BITS'(i) == slot) begin
            cell_ctl[i].op = CELL_LOAD;
         end else if (do_pop) begin
            cell_ctl[i].op = CELL_FROM_NEXT;
         end else begin
            cell_ctl[i].op = CELL_HOLD;
         end
      end
   end

   // The row of cells; the ends take their missing neighbor from themselves.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      sipq_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl[g]),
         .cmp_key  (req_key),
         .load_key (key_ff),
         .load_tag (tag_ff),
         .prev_key (cell_key[(g == 0) ? 0 : g - 1]),
         .prev_tag (cell_tag[(g == 0) ? 0 : g - 1]),
         .next_key (cell_key[(g == DEPTH - 1) ? g : g + 1]),
         .next_tag (cell_tag[(g == DEPTH - 1) ? g : g + 1]),
         .key      (cell_key[g]),
         .tag      (cell_tag[g]),
         .behind   (cell_behind[g])
      );
   end

   sipq_slot_find u_slot_find (
      .clock  (clock),
      .enable (state_ff == ST_FIND),
      .behind (cell_behind),
      .count  (count_ff),
      .slot   (slot)
   );

   // Result fields of the finished item.
   always_comb begin
      if (action_ff == ACT_INSERT) begin
         status_in = is_full ? STATUS_FULL : STATUS_OK;
      end else begin
         status_in = is_empty ? STATUS_EMPTY : STATUS_OK;
      end
      out_key_in   = do_pop ? cell_key[0] : '0;
      out_tag_in   = do_pop ? cell_tag[0] : '0;
      slot_out_in  = do_ins ? slot : '0;
      rsp_valid_in = apply_go ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         order_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers of the accepted item and of the result.
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         key_ff    <= req_key;
         tag_ff    <= req_tag;
      end
      if (apply_go) begin
         status_ff   <= status_in;
         out_key_ff  <= out_key_in;
         out_tag_ff  <= out_tag_in;
         slot_out_ff <= slot_out_in;
         occ_ff      <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_key     = out_key_ff;
   assign rsp_out_tag     = out_tag_ff;
   assign rsp_insert_slot = slot_out_ff;
   assign rsp_occupancy   = occ_ff;

   // Checks on the sequencer, the fill count and the reported status.
   `SIPQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1,
      count_ff <= COUNT_BITS'(DEPTH), "fill count above depth")
   `SIPQ_ASSERT_NEXT(a_one_at_a_time, clock, reset, accept,
      req_stall && state_ff == ST_FIND, "item accepted while busy")
   `SIPQ_ASSERT_SAME(a_full_status, clock, reset, rsp_valid_ff && status_ff == STATUS_FULL,
      occ_ff == COUNT_BITS'(DEPTH), "full refusal with room left")
   `SIPQ_ASSERT_SAME(a_empty_status, clock, reset, rsp_valid_ff && status_ff == STATUS_EMPTY,
      occ_ff == '0 && out_key_ff == '0, "empty refusal with entries held")

endmodule

`default_nettype wire

FILE: rtl/sipq_cell.sv
// One storage cell of the queue: holds a key and a tag, compares its key
// against a new key and shifts with its neighbors. Depends on sipq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sipq_cell (
   input  logic                   clock,
   input  sipq_pkg::cell_ctl_type ctl,
   input  sipq_pkg::key_type      cmp_key,
   input  sipq_pkg::key_type      load_key,
   input  sipq_pkg::tag_type      load_tag,
   input  sipq_pkg::key_type      prev_key,
   input  sipq_pkg::tag_type      prev_tag,
   input  sipq_pkg::key_type      next_key,
   input  sipq_pkg::tag_type      next_tag,
   output sipq_pkg::key_type      key,
   output sipq_pkg::tag_type      tag,
   output logic                   behind
);
   import sipq_pkg::*;

   key_type key_ff, key_in;
   tag_type tag_ff, tag_in;
   logic    behind_ff, behind_in;

   // Select the new contents from this cell, its neighbors or the new entry.
   always_comb begin
      case (ctl.op)
         CELL_HOLD: begin
            key_in = key_ff;
            tag_in = tag_ff;
         end
         CELL_FROM_PREV: begin
            key_in = prev_key;
            tag_in = prev_tag;
         end
         CELL_FROM_NEXT: begin
            key_in = next_key;
            tag_in = next_tag;
         end
         CELL_LOAD: begin
            key_in = load_key;
            tag_in = load_tag;
         end
         default: begin
            key_in = key_ff;
            tag_in = tag_ff;
         end
      endcase
   end

   // The held key moves behind the new one when it is larger in ascending
   // order, or not larger in descending order.
   always_comb begin
      if (ctl.cmp_en) begin
         behind_in = ctl.ascend ? (key_ff > cmp_key) : (key_ff <= cmp_key);
      end else begin
         behind_in = behind_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      tag_ff    <= tag_in;
      behind_ff <= behind_in;
   end

   assign key    = key_ff;
   assign tag    = tag_ff;
   assign behind = behind_ff;

endmodule

`default_nettype wire

FILE: rtl/sipq_slot_find.sv
// Insert position finder: the slot just past the last held entry that stays
// ahead of the new one, registered. Depends on sipq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sipq_slot_find (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [sipq_pkg::DEPTH-1:0]  behind,
   input  sipq_pkg::count_type         count,
   output sipq_pkg::slot_type          slot
);
   import sipq_pkg::*;

   slot_type          slot_ff, slot_in;
   logic [DEPTH-1:0]  stop;

   // A held entry stops the walk from the tail when it does not move back.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         stop[i] = ~behind[i] && (COUNT_BITS'(i) < count);
      end
   end

   // Highest stopping entry wins; the new entry lands right behind it.
   always_comb begin
      slot_in = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (stop[i]) begin
            slot_in = SLOT_BITS'(i + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         slot_ff <= slot_in;
      end
   end

   assign slot = slot_ff;

endmodule

`default_nettype wire

FILE: bench/sorted_insertion_priority_queue_core_test.sv
// Self-checking bench for the sorted insertion priority queue core. Directed and
// random insert/pop traffic is checked against a sorted-array predictor.
// Depends on sipq_pkg and the core RTL only.
`timescale 1ns / 1ps

module sorted_insertion_priority_queue_core_test;
   import sipq_pkg::*;

   localparam int PIPE_LATENCY   = 3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;
   localparam int PHASE_ITEMS    = 80;
   localparam logic [CSR_ADDR_BITS-1:0] ORDER_ADDR = CSR_ADDR_BITS'(4 * REG_ORDER);

   // One result item of the queue, field by field.
   typedef struct packed {
      logic [1:0] status;
      key_type    out_key;
      tag_type    out_tag;
      slot_type   slot;
      count_type  occupancy;
   } queue_result_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_valid  = 1'b0;
   logic                     req_stall;
   logic                     req_action = ACT_INSERT;
   key_type                  req_key    = '0;
   tag_type                  req_tag    = '0;
   logic                     rsp_valid;
   logic                     rsp_stall  = 1'b0;
   logic [1:0]               rsp_status;
   key_type                  rsp_out_key;
   tag_type                  rsp_out_tag;
   slot_type                 rsp_insert_slot;
   count_type                rsp_occupancy;
   logic                     psel       = 1'b0;
   logic                     penable    = 1'b0;
   logic                     pwrite     = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr      = '0;
   logic [CSR_DATA_BITS-1:0] pwdata     = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   // Predicted queue contents and order setting.
   key_type held_keys [DEPTH];
   tag_type held_tags [DEPTH];
   int      held_count  = 0;
   logic    ascend_mode = 1'b0;

   queue_result_type pending_results [$];

   int mismatch_count  = 0;
   int results_checked = 0;
   int items_accepted  = 0;
   int full_refusals   = 0;
   int empty_refusals  = 0;
   int peak_occupancy  = 0;
   int order_writes    = 0;
   int quiet_cycles    = 0;
   bit gaps_on         = 1'b1;
   bit stalls_on       = 1'b1;

   sorted_insertion_priority_queue_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_key         (req_key),
      .req_tag         (req_tag),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_tag     (rsp_out_tag),
      .rsp_insert_slot (rsp_insert_slot),
      .rsp_occupancy   (rsp_occupancy),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial forever #10 clock = ~clock;

   // A held entry moves behind the new one when it ranks lower under the
   // current order; in descending order equal keys also move back.
   function automatic logic yields_to_new(key_type held, key_type fresh);
      if (ascend_mode) begin
         return held > fresh;
      end
      return held <= fresh;
   endfunction

   // Applies one operation to the predicted queue and returns its result.
   function automatic queue_result_type apply_operation(logic act, key_type k, tag_type t);
      queue_result_type res;
      int pos;
      res = '0;
      res.status = STATUS_OK;
      if (act == ACT_INSERT) begin
         if (held_count >= DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            pos = held_count;
            while (pos > 0 && yields_to_new(held_keys[pos-1], k)) begin
               held_keys[pos] = held_keys[pos-1];
               held_tags[pos] = held_tags[pos-1];
               pos--;
            end
            held_keys[pos] = k;
            held_tags[pos] = t;
            held_count++;
            res.slot = slot_type'(pos);
         end
      end else if (held_count == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         res.out_key = held_keys[0];
         res.out_tag = held_tags[0];
         for (int i = 1; i < held_count; i++) begin
            held_keys[i-1] = held_keys[i];
            held_tags[i-1] = held_tags[i];
         end
         held_count--;
      end
      res.occupancy = count_type'(held_count);
      return res;
   endfunction

   // Keys lean toward a narrow range so that ties are common.
   function automatic key_type pick_key();
      case ($urandom_range(0, 5))
         0: begin
            return $urandom_range(0, 1) ? '1 : '0;
         end
         1, 2: begin
            return key_type'($urandom_range(0, 7));
         end
         default: begin
            return key_type'($urandom_range(0, 65535));
         end
      endcase
   endfunction

   // Predict on every accepted item and check every accepted result.
   always @(posedge clock) begin : monitor
      queue_result_type seen;
      queue_result_type want;
      logic moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            want = apply_operation(req_action, req_key, req_tag);
            pending_results.push_back(want);
            items_accepted++;
            if (want.status == STATUS_FULL) full_refusals++;
            if (want.status == STATUS_EMPTY) empty_refusals++;
            if (int'(want.occupancy) > peak_occupancy) peak_occupancy = int'(want.occupancy);
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            seen = '{rsp_status, rsp_out_key, rsp_out_tag, rsp_insert_slot, rsp_occupancy};
            results_checked++;
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("Result %0d arrived with no item outstanding.", results_checked);
            end else begin
               want = pending_results.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"Result %0d: status exp %0d got %0d, key exp %h got %h, ",
                               "tag exp %h got %h, slot exp %0d got %0d, ",
                               "occupancy exp %0d got %0d"},
                              results_checked, want.status, seen.status,
                              want.out_key, seen.out_key, want.out_tag, seen.out_tag,
                              want.slot, seen.slot, want.occupancy, seen.occupancy);
               end
            end
         end
      end
      quiet_cycles = (reset || moved) ? 0 : quiet_cycles + 1;
   end

   // Result-side back-pressure in random bursts.
   initial begin : result_stalls
      forever begin
         @(posedge clock);
         if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // End the run if nothing moves on either channel for too long.
   initial begin : watchdog
      do @(posedge clock); while (quiet_cycles < WATCHDOG_LIMIT);
      $display("No item moved for %0d cycles; run abandoned.", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Offers one item and returns at the edge where it is accepted. Valid stays
   // high afterwards so that back-to-back items flow without a bubble.
   task automatic send_item(input logic act, input key_type k, input tag_type t);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_key    <= k;
      req_tag    <= t;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_pop();
      send_item(ACT_POP, pick_key(), tag_type'($urandom_range(0, 255)));
   endtask

   // Stops the input side and waits until every result has come back. The
   // first edge lets the monitor record an item accepted at the current edge.
   task automatic settle_queue();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   // Writes the order register while the block is idle, then reads it back.
   task automatic write_order(input logic ascend);
      logic [CSR_DATA_BITS-1:0] readback;
      settle_queue();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ORDER_ADDR;
      pwdata  <= CSR_DATA_BITS'(ascend);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      ascend_mode = ascend;
      order_writes++;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback[0] !== ascend) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("Order register read back %0b after writing %0b.", readback[0], ascend);
      end
   endtask

   // Descending order from reset: empty pop, key extremes and newest-first ties.
   task automatic test_empty_and_extremes();
      send_pop();
      send_item(ACT_INSERT, 16'h0000, 8'h00);
      send_item(ACT_INSERT, 16'hFFFF, 8'hFF);
      send_item(ACT_INSERT, 16'h1234, 8'h01);
      send_item(ACT_INSERT, 16'h1234, 8'h02);
      send_item(ACT_INSERT, 16'h1234, 8'h03);
      repeat (6) send_pop();
   endtask

   // Ascending order with oldest-first ties, then a switch back to descending
   // while entries are still held, which must not re-sort them.
   task automatic test_order_and_ties();
      write_order(1'b1);
      send_item(ACT_INSERT, 16'h0005, 8'h10);
      send_item(ACT_INSERT, 16'h0005, 8'h11);
      send_item(ACT_INSERT, 16'h0000, 8'h5A);
      send_item(ACT_INSERT, 16'hFFFF, 8'hC3);
      send_item(ACT_INSERT, 16'h0005, 8'h12);
      write_order(1'b0);
      send_item(ACT_INSERT, 16'h0005, 8'h20);
      send_item(ACT_INSERT, 16'h0003, 8'h21);
      repeat (8) send_pop();
   endtask

   // Rising keys in ascending order land at the tail, so every slot is
   // reported; then inserts on a full queue and a drain to empty.
   task automatic test_fill_and_overflow();
      write_order(1'b1);
      for (int i = 0; i < DEPTH; i++) begin
         send_item(ACT_INSERT, key_type'(i * 1000 + $urandom_range(0, 999)),
                   tag_type'($urandom_range(0, 255)));
      end
      repeat (3) send_item(ACT_INSERT, pick_key(), tag_type'($urandom_range(0, 255)));
      repeat (DEPTH + 1) send_pop();
   endtask

   // Mixed traffic in phases with different insert rates and order settings.
   task automatic test_random_traffic();
      int insert_pct [4] = '{70, 35, 90, 45};
      for (int phase = 0; phase < 4; phase++) begin
         write_order(phase[0]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 99) < insert_pct[phase])
               send_item(ACT_INSERT, pick_key(), tag_type'($urandom_range(0, 255)));
            else
               send_pop();
         end
      end
   endtask

   // Full-rate traffic with no gaps or stalls on either side.
   task automatic test_quiet_tail();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if ($urandom_range(0, 99) < 55)
            send_item(ACT_INSERT, pick_key(), tag_type'($urandom_range(0, 255)));
         else
            send_pop();
      end
   endtask

   initial begin : run
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_extremes();
      test_order_and_ties();
      test_fill_and_overflow();
      test_random_traffic();
      test_quiet_tail();
      settle_queue();
      $display("Ran %0d items and checked %0d results over %0d order settings.",
               items_accepted, results_checked, order_writes);
      $display("Saw %0d full-queue inserts, %0d empty-queue pops, peak occupancy %0d.",
               full_refusals, empty_refusals, peak_occupancy);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
